/* src/gain_scheduled_pid_step_macros.svh */
// Assertion macros shared by the gain-scheduled PID step modules
`ifndef GAIN_SCHEDULED_PID_STEP_MACROS_SVH
`define GAIN_SCHEDULED_PID_STEP_MACROS_SVH

// Same-cycle implication, checked outside reset
`define GSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define GSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gsp_pkg.sv */
// Types and constants of the gain-scheduled PID step
package gsp_pkg;

  localparam int APB_AW = 5;

  typedef struct packed {
    logic signed [15:0] target;
    logic signed [15:0] measured;
  } gsp_in_t;

  typedef struct packed {
    logic        [13:0] drive;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] d_term;
  } gsp_out_t;

  typedef struct packed {
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [15:0] kd_gain;
    logic [13:0] out_min;
    logic [13:0] out_max;
  } gsp_cfg_t;

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_OMIN = 3'd3,
    REG_OMAX = 3'd4
  } gsp_reg_t;

  typedef enum logic [1:0] {
    TERM_P = 2'd0,
    TERM_I = 2'd1,
    TERM_D = 2'd2
  } gsp_term_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_DELTA,
    S_SCALE,
    S_GAIN,
    S_PROD,
    S_TERM,
    S_SUM,
    S_LOAD
  } gsp_state_t;

  typedef struct packed {
    logic      cap_in;
    logic      calc_err;
    logic      calc_delta;
    logic      calc_scale;
    logic      gain_mul;
    logic      prod_mul;
    logic      term_wr;
    gsp_term_t term_sel;
    logic      sum;
    logic      load;
  } gsp_cmd_t;

  typedef struct packed {
    logic out_free;
  } gsp_stat_t;

  localparam logic [15:0] KP_RESET   = 16'd2560;
  localparam logic [15:0] KI_RESET   = 16'd51;
  localparam logic [15:0] KD_RESET   = 16'd8000;
  localparam logic [13:0] OMIN_RESET = 14'd16;
  localparam logic [13:0] OMAX_RESET = 14'd16000;

  // Rule thresholds in Q.4
  localparam logic [16:0] E_SMALL_TH  = 17'd80;
  localparam logic [16:0] E_LARGE_TH  = 17'd240;
  localparam logic [17:0] DE_SMALL_TH = 18'd32;
  localparam logic [17:0] DE_LARGE_TH = 18'd80;

  // Scales in Q1.8, KD_BASE in Q2.8
  localparam logic [8:0] SCALE_1P2  = 9'd307;
  localparam logic [8:0] SCALE_1P1  = 9'd282;
  localparam logic [8:0] SCALE_0P9  = 9'd230;
  localparam logic [8:0] SCALE_0P7  = 9'd179;
  localparam logic [8:0] SCALE_0P85 = 9'd218;
  localparam logic [8:0] SCALE_ONE  = 9'd256;
  localparam logic [9:0] KD_BASE    = 10'd512;
  localparam logic [8:0] KI_BASE    = 9'd384;
  localparam logic [8:0] KI_HIGH    = 9'd128;

  localparam int FRAC_SHIFT = 14;

endpackage

/* src/gain_scheduled_pid_step.sv */
// Gain-scheduled PID step: one control tick per input beat, one result per tick.
// Input channel in_valid/in_ready/in_data carries target and measured (Q12.4).
// Result channel out_valid/out_ready/out_data carries the clamped drive (Q10.4)
// and the saturated P, I and D terms (Q28.4).
// Gains and drive limits sit behind the APB-style port at byte addresses
// 0x00 kp_gain, 0x04 ki_gain, 0x08 kd_gain, 0x0C out_min, 0x10 out_max.
// A new beat is taken only while the sequencer is idle, after the previous tick
// has loaded its result. Each tick computes error, delta and schedule, then
// makes three passes through the multipliers shared by the P, I and D terms
// (gain times scale, times operand, shift and saturate), then sums and clamps.
// The result waits in an output register, so the next tick is accepted while it
// is stalled; a finished tick holds in its last step until that register frees.
// Synchronous reset restores the default gains and limits and zeroes the last
// error and the error sum; no result is pending after reset.
module gain_scheduled_pid_step
  import gsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gsp_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output gsp_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  gsp_cfg_t  cfg;
  gsp_cmd_t  cmd;
  gsp_stat_t stat;

  assign pready = 1'b1;

  gsp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  gsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* src/gsp_regs.sv */
// Configuration register bank behind the APB-style port
module gsp_regs
  import gsp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output gsp_cfg_t          cfg
);

  gsp_cfg_t cfg_r;
  gsp_reg_t reg_sel;

  assign reg_sel = gsp_reg_t'(paddr[APB_AW-1:2]);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain <= KP_RESET;
      cfg_r.ki_gain <= KI_RESET;
      cfg_r.kd_gain <= KD_RESET;
      cfg_r.out_min <= OMIN_RESET;
      cfg_r.out_max <= OMAX_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_KP:   cfg_r.kp_gain <= pwdata[15:0];
        REG_KI:   cfg_r.ki_gain <= pwdata[15:0];
        REG_KD:   cfg_r.kd_gain <= pwdata[15:0];
        REG_OMIN: cfg_r.out_min <= pwdata[13:0];
        REG_OMAX: cfg_r.out_max <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KP:   prdata = {16'd0, cfg_r.kp_gain};
      REG_KI:   prdata = {16'd0, cfg_r.ki_gain};
      REG_KD:   prdata = {16'd0, cfg_r.kd_gain};
      REG_OMIN: prdata = {18'd0, cfg_r.out_min};
      REG_OMAX: prdata = {18'd0, cfg_r.out_max};
      default:  prdata = 32'd0;
    endcase
  end

endmodule

/* src/gsp_ctrl.sv */
// Sequencer of the PID step: one item at a time through the shared multipliers
module gsp_ctrl
  import gsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  gsp_stat_t stat,
  output gsp_cmd_t  cmd
);

`include "gain_scheduled_pid_step_macros.svh"

  gsp_state_t state_r, state_nxt;
  gsp_term_t  term_r, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= TERM_P;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_ERR;
      S_ERR:   state_nxt = S_DELTA;
      S_DELTA: state_nxt = S_SCALE;
      S_SCALE: begin
        state_nxt = S_GAIN;
        term_nxt  = TERM_P;
      end
      S_GAIN:  state_nxt = S_PROD;
      S_PROD:  state_nxt = S_TERM;
      S_TERM: begin
        case (term_r)
          TERM_P: begin
            term_nxt  = TERM_I;
            state_nxt = S_GAIN;
          end
          TERM_I: begin
            term_nxt  = TERM_D;
            state_nxt = S_GAIN;
          end
          default: begin
            term_nxt  = TERM_P;
            state_nxt = S_SUM;
          end
        endcase
      end
      S_SUM:   state_nxt = S_LOAD;
      // hold until the output register can take the beat
      S_LOAD:  if (stat.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.term_sel = term_r;
    in_ready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.cap_in = in_valid;
      end
      S_ERR:   cmd.calc_err   = 1'b1;
      S_DELTA: cmd.calc_delta = 1'b1;
      S_SCALE: cmd.calc_scale = 1'b1;
      S_GAIN:  cmd.gain_mul   = 1'b1;
      S_PROD:  cmd.prod_mul   = 1'b1;
      S_TERM:  cmd.term_wr    = 1'b1;
      S_SUM:   cmd.sum        = 1'b1;
      S_LOAD:  cmd.load       = stat.out_free;
      default: ;
    endcase
  end

  `GSP_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == S_ERR, "accepted beat did not start work")
  `GSP_ASSERT_NEXT(a_last_term_sums, (state_r == S_TERM) && (term_r == TERM_D), state_r == S_SUM, "sum not reached after derivative term")

endmodule

/* src/gsp_dp.sv */
// Datapath: error terms, gain schedule, shared multipliers, clamp and output register
module gsp_dp
  import gsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  gsp_in_t   in_data,
  input  gsp_cfg_t  cfg,
  input  gsp_cmd_t  cmd,
  output gsp_stat_t stat,
  output logic      out_valid,
  input  logic      out_ready,
  output gsp_out_t  out_data
);

`include "gain_scheduled_pid_step_macros.svh"

  logic signed [15:0] tgt_r, meas_r;
  logic signed [16:0] e_r, last_err_r;
  logic signed [17:0] de_r;
  logic signed [31:0] esum_r;
  logic        [8:0]  kps_r, kis_r, kds_r;
  logic        [24:0] g_r;
  logic signed [56:0] prod_r;
  logic signed [31:0] p_r, i_r, d_r;
  logic signed [33:0] sum_r;
  logic               out_valid_r;
  gsp_out_t           out_data_r;

  logic signed [32:0] esum_wide;
  logic signed [31:0] esum_sat;
  logic        [16:0] abs_e;
  logic        [17:0] abs_de;
  logic        [8:0]  scale;
  logic        [15:0] gain_mux;
  logic        [8:0]  scale_mux;
  logic signed [31:0] x_mux;
  logic signed [42:0] shifted;
  logic signed [31:0] term_sat;
  logic signed [33:0] min_ext, max_ext, lo_clamp, hi_clamp;

  assign esum_wide = {esum_r[31], esum_r} + {{16{e_r[16]}}, e_r};

  always_comb begin
    if (esum_wide[32] != esum_wide[31]) begin
      esum_sat = esum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      esum_sat = esum_wide[31:0];
    end
  end

  assign abs_e  = e_r[16] ? 17'(-e_r) : 17'(e_r);
  assign abs_de = de_r[17] ? 18'(-de_r) : 18'(de_r);

  // rule table on the error and its change
  always_comb begin
    if (abs_e < E_SMALL_TH) begin
      scale = SCALE_1P2;
    end else if (abs_e < E_LARGE_TH) begin
      scale = (abs_de < DE_SMALL_TH) ? SCALE_1P1 : SCALE_0P9;
    end else begin
      scale = (abs_de > DE_LARGE_TH) ? SCALE_0P7 : SCALE_0P85;
    end
  end

  always_comb begin
    case (cmd.term_sel)
      TERM_P: begin
        gain_mux  = cfg.kp_gain;
        scale_mux = kps_r;
        x_mux     = 32'(e_r);
      end
      TERM_I: begin
        gain_mux  = cfg.ki_gain;
        scale_mux = kis_r;
        x_mux     = esum_r;
      end
      default: begin
        gain_mux  = cfg.kd_gain;
        scale_mux = kds_r;
        x_mux     = 32'(de_r);
      end
    endcase
  end

  // floor shift is an arithmetic shift of the exact product
  assign shifted = prod_r[56:FRAC_SHIFT];

  always_comb begin
    if ((&shifted[42:31]) || !(|shifted[42:31])) begin
      term_sat = shifted[31:0];
    end else begin
      term_sat = shifted[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign min_ext  = $signed({20'd0, cfg.out_min});
  assign max_ext  = $signed({20'd0, cfg.out_max});
  assign lo_clamp = (sum_r < min_ext) ? min_ext : sum_r;
  assign hi_clamp = (lo_clamp > max_ext) ? max_ext : lo_clamp;

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      tgt_r  <= in_data.target;
      meas_r <= in_data.measured;
    end
    if (cmd.calc_err) begin
      e_r <= {tgt_r[15], tgt_r} - {meas_r[15], meas_r};
    end
    if (cmd.calc_delta) begin
      de_r <= {e_r[16], e_r} - {last_err_r[16], last_err_r};
    end
    if (cmd.calc_scale) begin
      kps_r <= scale;
      if (scale > SCALE_ONE) begin
        kds_r <= 9'(KD_BASE - {1'b0, scale});
        kis_r <= KI_HIGH;
      end else begin
        kds_r <= scale;
        kis_r <= KI_BASE - {1'b0, scale[8:1]};
      end
    end
    if (cmd.gain_mul) begin
      g_r <= {9'd0, gain_mux} * {16'd0, scale_mux};
    end
    if (cmd.prod_mul) begin
      prod_r <= $signed({1'b0, g_r}) * x_mux;
    end
    if (cmd.term_wr) begin
      case (cmd.term_sel)
        TERM_P:  p_r <= term_sat;
        TERM_I:  i_r <= term_sat;
        default: d_r <= term_sat;
      endcase
    end
    if (cmd.sum) begin
      sum_r <= 34'(p_r) + 34'(i_r) + 34'(d_r);
    end
    if (cmd.load) begin
      out_data_r.drive  <= hi_clamp[13:0];
      out_data_r.p_term <= p_r;
      out_data_r.i_term <= i_r;
      out_data_r.d_term <= d_r;
    end
  end

  // controller state carried from tick to tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      esum_r     <= '0;
    end else if (cmd.calc_delta) begin
      last_err_r <= e_r;
      esum_r     <= esum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  `GSP_ASSERT_NOW(a_load_when_free, cmd.load, !out_valid_r || out_ready, "result loaded over an unsent beat")
  `GSP_ASSERT_NOW(a_drive_in_limits, out_valid_r && (cfg.out_min <= cfg.out_max), (out_data_r.drive >= cfg.out_min) && (out_data_r.drive <= cfg.out_max), "drive outside limits")

endmodule
